### src/saa_pkg.sv
// Shared types, constants and the width alignment function of the skyline atlas allocator.
`default_nettype none

package saa_pkg;

  localparam int BLOCK_WIDTH_DEF  = 128;
  localparam int BLOCK_HEIGHT_DEF = 128;

  // Rounding never needs more than three increments to reach a multiple of four bytes.
  localparam int ALIGN_STEPS = 3;
  localparam int ALIGNED_W   = 9;

  localparam logic [2:0] TEXEL_BYTES_RST = 3'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] block_id;
  } saa_in_t;

  typedef struct packed {
    logic       granted;
    logic [6:0] pos_s;
    logic [7:0] pos_t;
    logic [7:0] aligned_width;
    logic [7:0] block_id_out;
  } saa_out_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } saa_seq_stat_t;

  // Width is rounded up until width times texel bytes is a multiple of four.
  // Only the two low bits of each operand matter for that test.
  function automatic logic [ALIGNED_W-1:0] saa_align(input logic [7:0] w,
                                                     input logic [2:0] tb);
    logic [ALIGNED_W-1:0] wa;
    logic [1:0]           prod;
    wa = {1'b0, w};
    for (int k = 0; k < ALIGN_STEPS; k++) begin
      prod = wa[1:0] * tb[1:0];
      if (prod != 2'd0) begin
        wa = wa + ALIGNED_W'(1);
      end
    end
    return wa;
  endfunction

endpackage

`default_nettype wire

### src/saa_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module saa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/saa_seq.sv
// Sequencer that clears, scans and raises the column height memory one column per cycle.
`default_nettype none

module saa_seq #(
  parameter int BLOCK_WIDTH  = saa_pkg::BLOCK_WIDTH_DEF,
  parameter int BLOCK_HEIGHT = saa_pkg::BLOCK_HEIGHT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire saa_pkg::saa_in_t                    req_i,
  input  wire logic [2:0]                          texel_bytes_i,
  input  wire logic                                hold_i,
  output saa_pkg::saa_seq_stat_t                   stat_o,
  output saa_pkg::saa_out_t                        res_o,
  output logic                                     we_o,
  output logic [$clog2(BLOCK_WIDTH)-1:0]           waddr_o,
  output logic [$clog2(BLOCK_HEIGHT+1)-1:0]        wdata_o,
  output logic [$clog2(BLOCK_WIDTH)-1:0]           raddr_o,
  input  wire logic [$clog2(BLOCK_HEIGHT+1)-1:0]   rdata_i
);

  import saa_pkg::*;

  localparam int CW = $clog2(BLOCK_WIDTH);
  localparam int XW = $clog2(BLOCK_WIDTH + 1);
  localparam int HW = $clog2(BLOCK_HEIGHT + 1);
  localparam int AW = (XW > ALIGNED_W) ? XW : ALIGNED_W;
  localparam int SW = ((HW > 8) ? HW : 8) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [XW-1:0]   i_q, i_d;
  logic [XW-1:0]   j_q, j_d;
  logic [XW-1:0]   w_q, w_d;
  logic [XW-1:0]   lim_q, lim_d;
  logic [HW-1:0]   top_q, top_d;
  logic [HW-1:0]   best_q, best_d;
  logic [HW-1:0]   sel_t_q, sel_t_d;
  logic [CW-1:0]   sel_s_q, sel_s_d;
  logic [HW-1:0]   nh_q, nh_d;
  logic [7:0]      rh_q, rh_d;
  logic            found_q, found_d;
  logic            clr_item_q, clr_item_d;
  saa_out_t        res_q, res_d;

  logic [ALIGNED_W-1:0] w_al;
  logic [AW-1:0]        w_wide;
  logic [HW-1:0]        top_new;
  logic [SW-1:0]        sum;

  assign w_al    = saa_align(req_i.rect_width, texel_bytes_i);
  assign w_wide  = AW'(w_al);
  assign top_new = (rdata_i > top_q) ? rdata_i : top_q;
  assign sum     = SW'(best_q) + SW'(rh_q);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    w_d        = w_q;
    lim_d      = lim_q;
    top_d      = top_q;
    best_d     = best_q;
    sel_t_d    = sel_t_q;
    sel_s_d    = sel_s_q;
    nh_d       = nh_q;
    rh_d       = rh_q;
    found_d    = found_q;
    clr_item_d = clr_item_q;
    res_d      = res_q;
    we_o       = 1'b0;
    waddr_o    = '0;
    wdata_o    = '0;
    raddr_o    = '0;
    stat_o     = '{idle: 1'b0, done: 1'b0};

    case (state_q)
      ST_IDLE: begin
        stat_o.idle = 1'b1;
        if (start_i) begin
          res_d.block_id_out = req_i.block_id;
          rh_d               = req_i.rect_height;
          if (req_i.action == ACT_CLEAR) begin
            clr_item_d = 1'b1;
            j_d        = '0;
            state_d    = ST_CLEAR;
          end else begin
            res_d.aligned_width = (w_al > ALIGNED_W'(255)) ? 8'hFF : w_al[7:0];
            w_d     = XW'(w_al);
            lim_d   = XW'(BLOCK_WIDTH) - XW'(w_al);
            i_d     = '0;
            j_d     = '0;
            top_d   = '0;
            best_d  = HW'(BLOCK_HEIGHT);
            sel_s_d = '0;
            sel_t_d = '0;
            found_d = 1'b0;
            if (w_wide >= AW'(BLOCK_WIDTH)) begin
              state_d = ST_DECIDE;
            end else if (w_al == '0) begin
              // An empty span fits everywhere; the last column is taken as its start.
              sel_s_d = CW'(BLOCK_WIDTH - 1);
              best_d  = '0;
              found_d = 1'b1;
              state_d = ST_DECIDE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = j_q[CW-1:0];
        if (j_q == XW'(BLOCK_WIDTH - 1)) begin
          if (clr_item_q) begin
            res_d.granted       = 1'b1;
            res_d.pos_s         = '0;
            res_d.pos_t         = '0;
            res_d.aligned_width = '0;
            state_d             = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          j_d = j_q + XW'(1);
        end
      end

      ST_SCAN: begin
        // The read data belongs to column i_q + j_q.
        if (rdata_i >= best_q) begin
          // Every start up to this column holds it, so skip past it.
          i_d   = i_q + j_q + XW'(1);
          j_d   = '0;
          top_d = '0;
        end else if (j_q == w_q - XW'(1)) begin
          sel_s_d = CW'(i_q);
          sel_t_d = top_new;
          best_d  = top_new;
          found_d = 1'b1;
          i_d     = i_q + XW'(1);
          j_d     = '0;
          top_d   = '0;
        end else begin
          j_d   = j_q + XW'(1);
          top_d = top_new;
        end
        raddr_o = CW'(i_d + j_d);
        if (i_d >= lim_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (!found_q || sum > SW'(BLOCK_HEIGHT)) begin
          res_d.granted = 1'b0;
          res_d.pos_s   = '0;
          res_d.pos_t   = '0;
          state_d       = ST_DONE;
        end else begin
          res_d.granted = 1'b1;
          res_d.pos_s   = 7'(sel_s_q);
          res_d.pos_t   = 8'(sel_t_q);
          nh_d          = HW'(sum);
          j_d           = '0;
          state_d       = (w_q == '0) ? ST_DONE : ST_WRITE;
        end
      end

      ST_WRITE: begin
        we_o    = 1'b1;
        waddr_o = CW'(XW'(sel_s_q) + j_q);
        wdata_o = nh_q;
        if (j_q == w_q - XW'(1)) begin
          state_d = ST_DONE;
        end else begin
          j_d = j_q + XW'(1);
        end
      end

      ST_DONE: begin
        if (!hold_i) begin
          stat_o.done = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      j_q        <= '0;
      clr_item_q <= 1'b0;
      i_q        <= '0;
      w_q        <= '0;
      lim_q      <= '0;
      top_q      <= '0;
      best_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      j_q        <= j_d;
      clr_item_q <= clr_item_d;
      i_q        <= i_d;
      w_q        <= w_d;
      lim_q      <= lim_d;
      top_q      <= top_d;
      best_q     <= best_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_t_q <= sel_t_d;
    sel_s_q <= sel_s_d;
    nh_q    <= nh_d;
    rh_q    <= rh_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### src/skyline_atlas_allocator_core.sv
// Top level of the skyline atlas allocator: configuration register, output register, sequencer and memory.
//
//   Channel   Direction  Handshake                   Payload
//   in        request    in_valid_i / in_ready_o     in_data_i  (saa_in_t)
//   out       result     out_valid_o / out_ready_i   out_data_o (saa_out_t)
//   cfg       write      cfg_valid_i / cfg_ready_o   cfg_data_i (texel bytes)
//
// After reset the column memory is swept to zero, one column a cycle, and no
// transaction is taken on the request channel until that sweep is done.
// A clear sweeps every column back to zero. An allocation scans the columns with
// R reads, one read per cycle on the single memory read port, where R is at most
// (BLOCK_WIDTH - W) * W for the aligned width W and far fewer when tall columns let
// the scan skip ahead; if the rectangle fits, it then writes the new height into W columns.
// One request is worked on at a time; a finished result waits in the output
// register, and the sequencer holds in its final state while that full register is not read.

`default_nettype none

module skyline_atlas_allocator_core #(
  parameter int BLOCK_WIDTH  = saa_pkg::BLOCK_WIDTH_DEF,
  parameter int BLOCK_HEIGHT = saa_pkg::BLOCK_HEIGHT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire saa_pkg::saa_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output saa_pkg::saa_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_data_i
);

  import saa_pkg::*;

  localparam int CW = $clog2(BLOCK_WIDTH);
  localparam int HW = $clog2(BLOCK_HEIGHT + 1);

  // Bytes per texel, used only when an allocation request is taken.
  logic [2:0]    texel_q, texel_d;

  logic          out_valid_q, out_valid_d;
  saa_out_t      out_data_q;

  saa_seq_stat_t stat;
  saa_out_t      res;
  logic          start;
  logic          hold;

  logic          we;
  logic [CW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic [CW-1:0] raddr;
  logic [HW-1:0] rdata;

  // The configuration register can always be written; the caller is to write it
  // only while no request is in flight, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;
  assign texel_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : texel_q;

  assign in_ready_o = stat.idle;
  assign start      = in_valid_i && in_ready_o;

  // The sequencer must not overwrite a result that has not yet been taken.
  assign hold        = out_valid_q && !out_ready_i;
  assign out_valid_d = stat.done ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      texel_q     <= TEXEL_BYTES_RST;
      out_valid_q <= 1'b0;
    end else begin
      texel_q     <= texel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  saa_seq #(
    .BLOCK_WIDTH  (BLOCK_WIDTH),
    .BLOCK_HEIGHT (BLOCK_HEIGHT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (in_data_i),
    .texel_bytes_i (texel_q),
    .hold_i        (hold),
    .stat_o        (stat),
    .res_o         (res),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  // One height per column of the block.
  saa_ram #(
    .WIDTH (HW),
    .DEPTH (BLOCK_WIDTH)
  ) u_heights (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

### src/saa_checker.sv
// Port-level assertions for the skyline atlas allocator and the bind that attaches them.
`default_nettype none

module saa_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire saa_pkg::saa_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire saa_pkg::saa_out_t out_data_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [2:0]        cfg_data_i
);

  import saa_pkg::*;

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // No request is finished in the cycle straight after it is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // A refused rectangle reports no position.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |-> out_data_o.pos_s == '0 && out_data_o.pos_t == '0)
    else $error("refused rectangle with a position");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind skyline_atlas_allocator_core saa_checker u_saa_checker (.*);

`default_nettype wire
